### design/bpp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bpp_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_BITS  = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_QM_HALF_DT     = 2'd0,
    REG_STEP_OVER_CELL = 2'd1
  } reg_idx_e;

endpackage
`default_nettype wire

### design/bpp_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface bpp_in_if
  import bpp_pkg::*;
#(
  parameter int W = WORD_BITS_DEF
);
  logic         valid;
  logic         ready;
  logic [W-1:0] position;
  logic [W-1:0] vel_x;
  logic [W-1:0] vel_y;
  logic [W-1:0] vel_z;
  logic [W-1:0] efield_x;
  logic [W-1:0] efield_y;
  logic [W-1:0] efield_z;
  logic [W-1:0] bfield_x;
  logic [W-1:0] bfield_y;
  logic [W-1:0] bfield_z;

  modport source (
    output valid, position, vel_x, vel_y, vel_z, efield_x, efield_y, efield_z,
           bfield_x, bfield_y, bfield_z,
    input  ready
  );
  modport sink (
    input  valid, position, vel_x, vel_y, vel_z, efield_x, efield_y, efield_z,
           bfield_x, bfield_y, bfield_z,
    output ready
  );
endinterface
`default_nettype wire

### design/bpp_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface bpp_out_if
  import bpp_pkg::*;
#(
  parameter int W = WORD_BITS_DEF
);
  logic         valid;
  logic         ready;
  logic [W-1:0] new_position;
  logic [W-1:0] new_vel_x;
  logic [W-1:0] new_vel_y;
  logic [W-1:0] new_vel_z;

  modport source (
    output valid, new_position, new_vel_x, new_vel_y, new_vel_z,
    input  ready
  );
  modport sink (
    input  valid, new_position, new_vel_x, new_vel_y, new_vel_z,
    output ready
  );
endinterface
`default_nettype wire

### design/boris_particle_push.sv
`timescale 1ns / 1ps
`default_nettype none
// Boris particle pusher. One particle word enters per cycle unless the
// output stalls; values are Q16.16 by default. The depth is set by the
// restoring divider for 2/(1+|T|^2), one quotient bit per pipeline stage;
// the rest latch inputs, seed the divider, or multiply, round and saturate-add.
// Every stage has its own valid bit and advances whenever the next stage
// can take its word, so bubbles collapse and a stall loses nothing.
// qm_half_dt and step_over_cell are read live and must only change while
// the pipeline is empty.
module boris_particle_push
  import bpp_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  wire logic [WORD_BITS-1:0]    cfg_wdata_i,
  bpp_in_if.sink                       in_i,
  bpp_out_if.source                    out_o
);

  localparam int W      = WORD_BITS;
  localparam int F      = FRAC_BITS;
  localparam int QB     = F + 2;
  localparam int NW     = W + F + 2;
  localparam int K_DIVI = 7;
  localparam int K_DIV0 = K_DIVI + 1;
  localparam int K_INV  = K_DIV0 + QB;
  localparam int NS     = K_INV + 8;

  localparam logic [W-1:0]   WMAX     = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]   WMIN     = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0]   ONE      = W'(1) << F;
  localparam logic [2*W-1:0] WMAX2    = (2*W)'(WMAX);
  localparam logic [2*W-1:0] WMIN2    = (2*W)'(WMIN);
  localparam logic [2*W-1:0] RND_HALF = (2*W)'(1) << (F-1);
  localparam logic [NW-1:0]  NUM_TWO  = NW'(1) << (2*F+1);
  localparam logic [QB-1:0]  QUO_MAX  = QB'(1) << (F+1);

  typedef struct packed {
    logic [W-1:0]        x;
    logic [W-1:0]        vx, vy, vz;
    logic [W-1:0]        ex, ey, ez;
    logic [W-1:0]        bx, by, bz;
    logic [W-1:0]        hx, hy, hz;
    logic [W-1:0]        tx, ty, tz;
    logic [W-1:0]        ux, uy, uz;
    logic [W-1:0]        px, py, pz;
    logic [W-1:0]        sx, sy, sz;
    logic [W-1:0]        dn;
    logic [5:0][2*W-1:0] pr;
    logic [NW-1:0]       rem;
    logic [QB-1:0]       quo;
  } stage_t;

  function automatic logic [2*W-1:0] mul(input logic [W-1:0] a, input logic [W-1:0] b);
    logic signed [2*W-1:0] sa, sb;
    sa = $signed({{W{a[W-1]}}, a});
    sb = $signed({{W{b[W-1]}}, b});
    return (2*W)'(sa * sb);
  endfunction

  // round half away from zero, then saturate
  function automatic logic [W-1:0] rnd(input logic [2*W-1:0] p);
    logic           neg;
    logic [2*W-1:0] m, r;
    neg = p[2*W-1];
    m   = neg ? (~p + (2*W)'(1)) : p;
    m   = m + RND_HALF;
    r   = m >> F;
    if (!neg) return (r > WMAX2) ? WMAX : r[W-1:0];
    return (r > WMIN2) ? WMIN : (~r[W-1:0] + W'(1));
  endfunction

  function automatic logic [W-1:0] sadd(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] ssub(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
    return s[W-1:0];
  endfunction

  logic [W-1:0]  qm_half_dt_q, step_over_cell_q;
  stage_t        pl_q [NS];
  stage_t        pl_d [NS];
  logic [NS-1:0] vld_q;
  logic [NS-1:0] en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qm_half_dt_q     <= '0;
      step_over_cell_q <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_QM_HALF_DT:     qm_half_dt_q     <= cfg_wdata_i;
        REG_STEP_OVER_CELL: step_over_cell_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    en[NS-1] = !vld_q[NS-1] || out_o.ready;
    for (int k = NS-2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_i.ready = en[0];

  always_comb begin
    logic [NW-1:0] sh;
    logic [W-1:0]  inv;
    sh  = '0;
    inv = '0;
    pl_d[0]    = '0;
    pl_d[0].x  = in_i.position;
    pl_d[0].vx = in_i.vel_x;
    pl_d[0].vy = in_i.vel_y;
    pl_d[0].vz = in_i.vel_z;
    pl_d[0].ex = in_i.efield_x;
    pl_d[0].ey = in_i.efield_y;
    pl_d[0].ez = in_i.efield_z;
    pl_d[0].bx = in_i.bfield_x;
    pl_d[0].by = in_i.bfield_y;
    pl_d[0].bz = in_i.bfield_z;
    for (int k = 1; k < NS; k++) begin
      pl_d[k] = pl_q[k-1];
      if (k == 1) begin
        pl_d[k].pr[0] = mul(qm_half_dt_q, pl_q[k-1].ex);
        pl_d[k].pr[1] = mul(qm_half_dt_q, pl_q[k-1].ey);
        pl_d[k].pr[2] = mul(qm_half_dt_q, pl_q[k-1].ez);
        pl_d[k].pr[3] = mul(qm_half_dt_q, pl_q[k-1].bx);
        pl_d[k].pr[4] = mul(qm_half_dt_q, pl_q[k-1].by);
        pl_d[k].pr[5] = mul(qm_half_dt_q, pl_q[k-1].bz);
      end else if (k == 2) begin
        pl_d[k].hx = rnd(pl_q[k-1].pr[0]);
        pl_d[k].hy = rnd(pl_q[k-1].pr[1]);
        pl_d[k].hz = rnd(pl_q[k-1].pr[2]);
        pl_d[k].tx = rnd(pl_q[k-1].pr[3]);
        pl_d[k].ty = rnd(pl_q[k-1].pr[4]);
        pl_d[k].tz = rnd(pl_q[k-1].pr[5]);
      end else if (k == 3) begin
        pl_d[k].ux    = sadd(pl_q[k-1].vx, pl_q[k-1].hx);
        pl_d[k].uy    = sadd(pl_q[k-1].vy, pl_q[k-1].hy);
        pl_d[k].uz    = sadd(pl_q[k-1].vz, pl_q[k-1].hz);
        pl_d[k].pr[0] = mul(pl_q[k-1].tx, pl_q[k-1].tx);
        pl_d[k].pr[1] = mul(pl_q[k-1].ty, pl_q[k-1].ty);
        pl_d[k].pr[2] = mul(pl_q[k-1].tz, pl_q[k-1].tz);
      end else if (k == 4) begin
        pl_d[k].dn    = sadd(ONE, rnd(pl_q[k-1].pr[0]));
        pl_d[k].sy    = rnd(pl_q[k-1].pr[1]);
        pl_d[k].sz    = rnd(pl_q[k-1].pr[2]);
        pl_d[k].pr[0] = mul(pl_q[k-1].uy, pl_q[k-1].tz);
        pl_d[k].pr[1] = mul(pl_q[k-1].uz, pl_q[k-1].ty);
        pl_d[k].pr[2] = mul(pl_q[k-1].uz, pl_q[k-1].tx);
        pl_d[k].pr[3] = mul(pl_q[k-1].ux, pl_q[k-1].tz);
        pl_d[k].pr[4] = mul(pl_q[k-1].ux, pl_q[k-1].ty);
        pl_d[k].pr[5] = mul(pl_q[k-1].uy, pl_q[k-1].tx);
      end else if (k == 5) begin
        pl_d[k].dn = sadd(pl_q[k-1].dn, pl_q[k-1].sy);
        pl_d[k].px = sadd(pl_q[k-1].ux, rnd(pl_q[k-1].pr[0]));
        pl_d[k].py = sadd(pl_q[k-1].uy, rnd(pl_q[k-1].pr[2]));
        pl_d[k].pz = sadd(pl_q[k-1].uz, rnd(pl_q[k-1].pr[4]));
      end else if (k == 6) begin
        pl_d[k].dn = sadd(pl_q[k-1].dn, pl_q[k-1].sz);
        pl_d[k].px = ssub(pl_q[k-1].px, rnd(pl_q[k-1].pr[1]));
        pl_d[k].py = ssub(pl_q[k-1].py, rnd(pl_q[k-1].pr[3]));
        pl_d[k].pz = ssub(pl_q[k-1].pz, rnd(pl_q[k-1].pr[5]));
      end else if (k == K_DIVI) begin
        pl_d[k].rem = NUM_TWO + NW'(pl_q[k-1].dn >> 1);
        pl_d[k].quo = '0;
      end else if (k >= K_DIV0 && k < K_INV) begin
        sh = NW'(pl_q[k-1].dn) << (QB - 1 - (k - K_DIV0));
        if (pl_q[k-1].rem >= sh) begin
          pl_d[k].rem = pl_q[k-1].rem - sh;
          pl_d[k].quo = {pl_q[k-1].quo[QB-2:0], 1'b1};
        end else begin
          pl_d[k].quo = {pl_q[k-1].quo[QB-2:0], 1'b0};
        end
      end else if (k == K_INV) begin
        inv = (NW'(pl_q[k-1].quo) > NW'(WMAX)) ? WMAX : W'(pl_q[k-1].quo);
        pl_d[k].pr[0] = mul(pl_q[k-1].tx, inv);
        pl_d[k].pr[1] = mul(pl_q[k-1].ty, inv);
        pl_d[k].pr[2] = mul(pl_q[k-1].tz, inv);
      end else if (k == K_INV + 1) begin
        pl_d[k].sx = rnd(pl_q[k-1].pr[0]);
        pl_d[k].sy = rnd(pl_q[k-1].pr[1]);
        pl_d[k].sz = rnd(pl_q[k-1].pr[2]);
      end else if (k == K_INV + 2) begin
        pl_d[k].pr[0] = mul(pl_q[k-1].py, pl_q[k-1].sz);
        pl_d[k].pr[1] = mul(pl_q[k-1].pz, pl_q[k-1].sy);
        pl_d[k].pr[2] = mul(pl_q[k-1].pz, pl_q[k-1].sx);
        pl_d[k].pr[3] = mul(pl_q[k-1].px, pl_q[k-1].sz);
        pl_d[k].pr[4] = mul(pl_q[k-1].px, pl_q[k-1].sy);
        pl_d[k].pr[5] = mul(pl_q[k-1].py, pl_q[k-1].sx);
      end else if (k == K_INV + 3) begin
        pl_d[k].px = sadd(pl_q[k-1].ux, rnd(pl_q[k-1].pr[0]));
        pl_d[k].py = sadd(pl_q[k-1].uy, rnd(pl_q[k-1].pr[2]));
        pl_d[k].pz = sadd(pl_q[k-1].uz, rnd(pl_q[k-1].pr[4]));
      end else if (k == K_INV + 4) begin
        pl_d[k].px = ssub(pl_q[k-1].px, rnd(pl_q[k-1].pr[1]));
        pl_d[k].py = ssub(pl_q[k-1].py, rnd(pl_q[k-1].pr[3]));
        pl_d[k].pz = ssub(pl_q[k-1].pz, rnd(pl_q[k-1].pr[5]));
      end else if (k == K_INV + 5) begin
        pl_d[k].vx = sadd(pl_q[k-1].px, pl_q[k-1].hx);
        pl_d[k].vy = sadd(pl_q[k-1].py, pl_q[k-1].hy);
        pl_d[k].vz = sadd(pl_q[k-1].pz, pl_q[k-1].hz);
      end else if (k == K_INV + 6) begin
        pl_d[k].pr[0] = mul(step_over_cell_q, pl_q[k-1].vx);
      end else if (k == K_INV + 7) begin
        pl_d[k].x = sadd(pl_q[k-1].x, rnd(pl_q[k-1].pr[0]));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_i.valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NS; k++) begin
      if (en[k]) pl_q[k] <= pl_d[k];
    end
  end

  assign out_o.valid        = vld_q[NS-1];
  assign out_o.new_position = pl_q[NS-1].x;
  assign out_o.new_vel_x    = pl_q[NS-1].vx;
  assign out_o.new_vel_y    = pl_q[NS-1].vy;
  assign out_o.new_vel_z    = pl_q[NS-1].vz;

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready)
    else $error("input blocked with output empty");

  a_den_at_least_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[K_DIVI-1] |-> ($signed(pl_q[K_DIVI-1].dn) >= $signed(ONE)))
    else $error("denominator below one");

  a_inv_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[K_INV-1] |-> (pl_q[K_INV-1].quo <= QUO_MAX))
    else $error("reciprocal above two");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NS-1] && !out_o.ready) |=> (vld_q[NS-1] && $stable(pl_q[NS-1].x)))
    else $error("stalled result changed");

endmodule
`default_nettype wire
